@@ rtl/tqe_pkg.sv @@
package tqe_pkg;

  localparam int TS_W = 7;

  localparam logic [1:0] REG_TILE_SIZE      = 2'd0;
  localparam logic [1:0] REG_AUTOTILE_KINDS = 2'd1;
  localparam logic [1:0] REG_PRIORITY_COUNT = 2'd2;

  localparam logic [1:0] KIND_ABSENT = 2'd0;
  localparam logic [1:0] KIND_STATIC = 2'd2;
  localparam logic [1:0] KIND_SINGLE = 2'd3;

  localparam logic [14:0] AUTOTILE_FIRST = 15'd48;
  localparam logic [14:0] TILESET_FIRST  = 15'd384;
  localparam logic [2:0]  PRIORITY_MAX   = 3'd5;

  // Quarter source pattern table: high nibble x, low nibble y, in half tiles.
  localparam logic [0:191][7:0] QSRC = {
    8'h24,8'h34,8'h25,8'h35,8'h40,8'h34,8'h25,8'h35,8'h24,8'h50,8'h25,8'h35,
    8'h40,8'h50,8'h25,8'h35,8'h24,8'h34,8'h25,8'h51,8'h40,8'h34,8'h25,8'h51,
    8'h24,8'h50,8'h25,8'h51,8'h40,8'h50,8'h25,8'h51,8'h24,8'h34,8'h41,8'h35,
    8'h40,8'h34,8'h41,8'h35,8'h24,8'h50,8'h41,8'h35,8'h40,8'h50,8'h41,8'h35,
    8'h24,8'h34,8'h41,8'h51,8'h40,8'h34,8'h41,8'h51,8'h24,8'h50,8'h41,8'h51,
    8'h40,8'h50,8'h41,8'h51,8'h04,8'h14,8'h05,8'h15,8'h04,8'h50,8'h05,8'h15,
    8'h04,8'h14,8'h05,8'h51,8'h04,8'h50,8'h05,8'h51,8'h22,8'h32,8'h23,8'h33,
    8'h22,8'h32,8'h23,8'h51,8'h22,8'h32,8'h41,8'h33,8'h22,8'h32,8'h41,8'h51,
    8'h44,8'h54,8'h45,8'h55,8'h44,8'h54,8'h41,8'h55,8'h40,8'h54,8'h45,8'h55,
    8'h40,8'h54,8'h41,8'h55,8'h26,8'h36,8'h27,8'h37,8'h40,8'h36,8'h27,8'h37,
    8'h26,8'h50,8'h27,8'h37,8'h40,8'h50,8'h27,8'h37,8'h04,8'h54,8'h05,8'h55,
    8'h22,8'h32,8'h27,8'h37,8'h02,8'h12,8'h03,8'h13,8'h02,8'h12,8'h03,8'h51,
    8'h42,8'h52,8'h43,8'h53,8'h42,8'h52,8'h41,8'h53,8'h46,8'h56,8'h47,8'h57,
    8'h40,8'h56,8'h47,8'h57,8'h06,8'h16,8'h07,8'h17,8'h06,8'h50,8'h07,8'h17,
    8'h02,8'h52,8'h03,8'h53,8'h02,8'h12,8'h07,8'h17,8'h06,8'h56,8'h07,8'h57,
    8'h42,8'h52,8'h47,8'h57,8'h02,8'h52,8'h07,8'h57,8'h00,8'h10,8'h01,8'h11
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_auto;
    logic        prio_ok;
    logic [6:0]  ts;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [2:0]  slot;
    logic [5:0]  pat;
    logic [2:0]  t_lo;
    logic [11:0] t_hi;
  } s1_t;

  typedef struct packed {
    logic            ground;
    logic [6:0]      layer;
    logic [6:0]      ts;
    logic [12:0]     px;
    logic [12:0]     py;
    logic            quarter;
    logic            stat;
    logic [11:0]     base_y;
    logic [19:0]     tx1;
    logic [19:0]     ty1;
    logic [3:0][7:0] ent;
  } s2_t;

  typedef struct packed {
    logic [3:0][19:0] tx;
    logic [3:0][19:0] ty;
    logic [6:0]       tsz;
    logic [12:0]      px;
    logic [12:0]      py;
    logic [7:0]       qs;
    logic [6:0]       ts;
    logic             quarter;
    logic             ground;
    logic [6:0]       layer;
  } cell_t;

endpackage

@@ rtl/tqe_front.sv @@
module tqe_front
  import tqe_pkg::*;
#(
  parameter int unsigned PRIORITY_DEPTH = 8192,
  parameter int unsigned VIEW_DIM = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [14:0] in_tile_id,
  input  logic [2:0]  in_priority_value,
  input  logic [5:0]  in_col,
  input  logic [5:0]  in_row,
  input  logic [6:0]  tile_size,
  input  logic [13:0] autotile_kinds,
  input  logic [13:0] priority_count,
  output logic        s1_valid,
  output s1_t         s1_data,
  output logic [2:0]  s1_prio,
  input  logic        s1_ready
);

  localparam int AW = $clog2(PRIORITY_DEPTH);

  logic [2:0] mem [PRIORITY_DEPTH];
  logic       s1_v_r;
  s1_t        s1_r;
  s1_t        s1_nxt;
  logic [2:0] rd_r;
  logic       acc;
  logic       cell_ok;
  logic       in_depth;
  logic [2:0] qd;
  logic [14:0] t;
  logic [6:0] ts;

  assign in_stall = s1_v_r && !s1_ready;
  assign acc      = in_valid && !in_stall;
  assign in_depth = {17'd0, in_tile_id} < PRIORITY_DEPTH;

  always_comb begin
    qd = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (in_tile_id >= 15'(48 * k)) qd = 3'(k);
    end
    ts = tile_size;
    if (tile_size == 7'd0) ts = 7'd1;
    else if (tile_size > 7'd64) ts = 7'd64;
    t = in_tile_id - TILESET_FIRST;
    s1_nxt.is_auto = in_tile_id < TILESET_FIRST;
    s1_nxt.slot    = qd - 3'd1;
    s1_nxt.kind    = autotile_kinds[{s1_nxt.slot, 1'b0} +: 2];
    s1_nxt.prio_ok = (in_tile_id < {1'b0, priority_count}) && in_depth;
    s1_nxt.ts      = ts;
    s1_nxt.col     = in_col;
    s1_nxt.row     = in_row;
    s1_nxt.pat     = 6'(in_tile_id[8:0] - 9'(qd) * 9'd48);
    s1_nxt.t_lo    = t[2:0];
    s1_nxt.t_hi    = t[14:3];
    cell_ok = in_func && ({3'd0, in_col} < VIEW_DIM[8:0]) && ({3'd0, in_row} < VIEW_DIM[8:0])
              && (in_tile_id >= AUTOTILE_FIRST)
              && !(s1_nxt.is_auto && s1_nxt.kind == KIND_ABSENT);
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (!in_func && in_depth) mem[in_tile_id[AW-1:0]] <= in_priority_value;
      rd_r <= mem[in_tile_id[AW-1:0]];
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!s1_v_r || s1_ready) begin
      s1_v_r <= acc && cell_ok;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_r;
  assign s1_prio  = rd_r;

endmodule

@@ rtl/tqe_calc.sv @@
module tqe_calc
  import tqe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s1_valid,
  input  s1_t        s1_data,
  input  logic [2:0] s1_prio,
  output logic       s1_ready,
  output logic       c_valid,
  output cell_t      c_data,
  input  logic       c_ready
);

  logic       s2_v_r;
  s2_t        s2_r;
  s2_t        s2_nxt;
  logic       s3_v_r;
  cell_t      s3_r;
  cell_t      s3_nxt;
  logic       s2_ready;
  logic       s3_ready;
  logic [2:0] prio;
  logic       keep;
  logic [7:0] ts2;
  logic [11:0] by;
  logic [8:0] xoff;

  assign s3_ready = !s3_v_r || c_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = s2_ready;

  always_comb begin
    prio = s1_data.prio_ok ? s1_prio : 3'd0;
    keep = prio <= PRIORITY_MAX;
    ts2  = {1'b0, s1_data.ts} << 1;
    by   = 12'(12'(s1_data.ts) * 12'(s1_data.slot));
    s2_nxt.ground  = prio == 3'd0;
    s2_nxt.layer   = s2_nxt.ground ? 7'd0 : 7'(s1_data.row) + 7'(prio);
    s2_nxt.ts      = s1_data.ts;
    s2_nxt.px      = 13'(14'(ts2) * 14'(s1_data.col));
    s2_nxt.py      = 13'(14'(ts2) * 14'(s1_data.row));
    s2_nxt.quarter = s1_data.is_auto && s1_data.kind != KIND_SINGLE;
    s2_nxt.stat    = s1_data.kind == KIND_STATIC;
    s2_nxt.base_y  = {by[8:0], 3'b000} + 12'd1;
    if (s1_data.is_auto) begin
      s2_nxt.tx1 = 20'd1;
      s2_nxt.ty1 = 20'(s2_nxt.base_y);
    end else begin
      s2_nxt.tx1 = 20'(20'(ts2) * (20'd12 + 20'(s1_data.t_lo))) + 20'd1;
      s2_nxt.ty1 = 20'(20'(ts2) * 20'(s1_data.t_hi)) + 20'd1;
    end
    for (int q = 0; q < 4; q++) begin
      s2_nxt.ent[q] = QSRC[{s1_data.pat, 2'(q)}];
    end
  end

  always_comb begin
    xoff = s2_r.stat ? 9'(9'(s2_r.ts) * 9'd6) : 9'd0;
    for (int q = 0; q < 4; q++) begin
      s3_nxt.tx[q] = 20'(11'(s2_r.ent[q][7:4]) * 11'(s2_r.ts)) + 20'(xoff) + 20'd1;
      s3_nxt.ty[q] = 20'(11'(s2_r.ent[q][3:0]) * 11'(s2_r.ts)) + 20'(s2_r.base_y);
    end
    if (!s2_r.quarter) begin
      s3_nxt.tx[0] = s2_r.tx1;
      s3_nxt.ty[0] = s2_r.ty1;
    end
    if (s2_r.quarter) begin
      s3_nxt.tsz = (s2_r.ts >= 7'd2) ? s2_r.ts - 7'd2 : 7'd0;
      s3_nxt.qs  = 8'(s2_r.ts);
    end else begin
      s3_nxt.tsz = 7'(({1'b0, s2_r.ts} << 1) - 8'd2);
      s3_nxt.qs  = {1'b0, s2_r.ts} << 1;
    end
    s3_nxt.px      = s2_r.px;
    s3_nxt.py      = s2_r.py;
    s3_nxt.ts      = s2_r.ts;
    s3_nxt.quarter = s2_r.quarter;
    s3_nxt.ground  = s2_r.ground;
    s3_nxt.layer   = s2_r.layer;
  end

  always_ff @(posedge clk) begin
    if (s2_ready) s2_r <= s2_nxt;
    if (s3_ready) s3_r <= s3_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s2_ready) s2_v_r <= s1_valid && keep;
      if (s3_ready) s3_v_r <= s2_v_r;
    end
  end

  assign c_valid = s3_v_r;
  assign c_data  = s3_r;

endmodule

@@ rtl/tqe_emit.sv @@
module tqe_emit
  import tqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        c_valid,
  input  cell_t       c_data,
  output logic        c_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_tex_x,
  output logic [19:0] out_tex_y,
  output logic [6:0]  out_tex_size,
  output logic [12:0] out_pos_x,
  output logic [12:0] out_pos_y,
  output logic [7:0]  out_quad_size,
  output logic        out_is_ground,
  output logic [6:0]  out_layer,
  output logic        out_last
);

  cell_t       cur_r;
  logic        cv_r;
  logic [1:0]  q_r;
  logic        ov_r;
  logic [19:0] tx_r;
  logic [19:0] ty_r;
  logic [6:0]  tsz_r;
  logic [12:0] px_r;
  logic [12:0] py_r;
  logic [7:0]  qs_r;
  logic        gnd_r;
  logic [6:0]  lay_r;
  logic        last_r;
  logic        load_out;
  logic        last_now;
  logic        take;

  assign load_out = !ov_r || !out_stall;
  assign last_now = !cur_r.quarter || q_r == 2'd3;
  assign c_ready  = !cv_r || (load_out && last_now);
  assign take     = c_valid && c_ready;

  always_ff @(posedge clk) begin
    if (take) cur_r <= c_data;
    if (load_out) begin
      tx_r   <= cur_r.tx[q_r];
      ty_r   <= cur_r.ty[q_r];
      tsz_r  <= cur_r.tsz;
      px_r   <= cur_r.px + ((cur_r.quarter && q_r[0]) ? 13'(cur_r.ts) : 13'd0);
      py_r   <= cur_r.py + ((cur_r.quarter && q_r[1]) ? 13'(cur_r.ts) : 13'd0);
      qs_r   <= cur_r.qs;
      gnd_r  <= cur_r.ground;
      lay_r  <= cur_r.layer;
      last_r <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
      q_r  <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      if (load_out) ov_r <= cv_r;
      if (take) begin
        cv_r <= 1'b1;
        q_r  <= 2'd0;
      end else if (cv_r && load_out) begin
        if (last_now) cv_r <= 1'b0;
        q_r <= q_r + 2'd1;
      end
    end
  end

  assign out_valid     = ov_r;
  assign out_tex_x     = tx_r;
  assign out_tex_y     = ty_r;
  assign out_tex_size  = tsz_r;
  assign out_pos_x     = px_r;
  assign out_pos_y     = py_r;
  assign out_quad_size = qs_r;
  assign out_is_ground = gnd_r;
  assign out_layer     = lay_r;
  assign out_last      = last_r;

endmodule

@@ rtl/tile_quad_expander.sv @@
// Tile quad expander: turns map cells into screen and atlas quads.
// Input channel (in_*): one transfer is either a priority table write
// (in_func low) or a map cell to expand (in_func high). Output channel
// (out_*): one transfer per quad; out_last marks the final quad of a cell.
// Autotile cells give four quads, single-animated autotiles and tileset
// tiles give one, and dropped cells give none.
// An input cell passes the s1, s2, s3 and current-cell registers before
// its first quad is registered at the output. A cell gives one output
// transfer per quad; s1, s2 and s3 take a new transfer every cycle unless
// stalled, so out_stall and the quad emitter alone limit throughput.
// Configuration is written through the APB-style cfg_ port; the user must
// write it only while idle, which the block does not enforce. After reset
// tile_size is 32 and the other registers are 0; the priority table is not
// cleared and must be written before ids below priority_count are expanded.
// While out_stall is high, valid stages hold and in_stall rises when full.
module tile_quad_expander
  import tqe_pkg::*;
#(
  parameter int unsigned PRIORITY_DEPTH = 8192,
  parameter int unsigned VIEW_DIM = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [14:0] in_tile_id,
  input  logic [2:0]  in_priority_value,
  input  logic [5:0]  in_col,
  input  logic [5:0]  in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_tex_x,
  output logic [19:0] out_tex_y,
  output logic [6:0]  out_tex_size,
  output logic [12:0] out_pos_x,
  output logic [12:0] out_pos_y,
  output logic [7:0]  out_quad_size,
  output logic        out_is_ground,
  output logic [6:0]  out_layer,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [6:0]  tile_size_r;
  logic [13:0] kinds_r;
  logic [13:0] pcount_r;
  logic        wr;
  logic        s1_valid;
  s1_t         s1_data;
  logic [2:0]  s1_prio;
  logic        s1_ready;
  logic        c_valid;
  cell_t       c_data;
  logic        c_ready;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= 7'd32;
      kinds_r     <= 14'd0;
      pcount_r    <= 14'd0;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        REG_TILE_SIZE:      tile_size_r <= cfg_pwdata[6:0];
        REG_AUTOTILE_KINDS: kinds_r     <= cfg_pwdata[13:0];
        REG_PRIORITY_COUNT: pcount_r    <= cfg_pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TILE_SIZE:      cfg_prdata = 32'(tile_size_r);
      REG_AUTOTILE_KINDS: cfg_prdata = 32'(kinds_r);
      REG_PRIORITY_COUNT: cfg_prdata = 32'(pcount_r);
      default:            cfg_prdata = 32'd0;
    endcase
  end

  tqe_front #(
    .PRIORITY_DEPTH(PRIORITY_DEPTH),
    .VIEW_DIM(VIEW_DIM)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_tile_id(in_tile_id),
    .in_priority_value(in_priority_value),
    .in_col(in_col),
    .in_row(in_row),
    .tile_size(tile_size_r),
    .autotile_kinds(kinds_r),
    .priority_count(pcount_r),
    .s1_valid(s1_valid),
    .s1_data(s1_data),
    .s1_prio(s1_prio),
    .s1_ready(s1_ready)
  );

  tqe_calc u_calc (
    .clk(clk),
    .rst_n(rst_n),
    .s1_valid(s1_valid),
    .s1_data(s1_data),
    .s1_prio(s1_prio),
    .s1_ready(s1_ready),
    .c_valid(c_valid),
    .c_data(c_data),
    .c_ready(c_ready)
  );

  tqe_emit u_emit (
    .clk(clk),
    .rst_n(rst_n),
    .c_valid(c_valid),
    .c_data(c_data),
    .c_ready(c_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tex_x(out_tex_x),
    .out_tex_y(out_tex_y),
    .out_tex_size(out_tex_size),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_quad_size(out_quad_size),
    .out_is_ground(out_is_ground),
    .out_layer(out_layer),
    .out_last(out_last)
  );

`ifndef NO_ASSERTIONS
  a_ground_layer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_ground |-> out_layer == 7'd0)
    else $error("ground quad with nonzero layer");

  a_above_layer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_ground |-> out_layer != 7'd0)
    else $error("above-layer quad with zero layer");

  a_quarter_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_quad_size <= 8'd64)
    else $error("non-final quad is not a quarter quad");
`endif

endmodule

@@ bench/tile_quad_expander_tb.sv @@
`timescale 1ns / 1ps

module tile_quad_expander_tb;
  import tqe_pkg::*;

  typedef struct {
    logic [19:0] tex_x;
    logic [19:0] tex_y;
    logic [6:0]  tex_size;
    logic [12:0] pos_x;
    logic [12:0] pos_y;
    logic [7:0]  quad_size;
    logic        is_ground;
    logic [6:0]  layer;
    logic        last;
  } quad_t;

  localparam int unsigned STORE_DEPTH = 8192;

  class quad_tracker;
    quad_t       expected_quads[$];
    logic [6:0]  tile_size;
    logic [13:0] kinds;
    logic [13:0] prio_count;
    logic [2:0]  prio_store[STORE_DEPTH];
    int          errors;

    function new();
      tile_size = 7'd32;
      kinds = '0;
      prio_count = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_TILE_SIZE: tile_size = value[6:0];
        REG_AUTOTILE_KINDS: kinds = value[13:0];
        REG_PRIORITY_COUNT: prio_count = value[13:0];
        default: ;
      endcase
    endfunction

    function void push_quad(int unsigned tx, int unsigned ty, int unsigned tsz,
                            int unsigned px, int unsigned py, int unsigned qs,
                            logic ground, int unsigned lay, logic lst);
      quad_t q;
      q.tex_x = 20'(tx);
      q.tex_y = 20'(ty);
      q.tex_size = 7'(tsz);
      q.pos_x = 13'(px);
      q.pos_y = 13'(py);
      q.quad_size = 8'(qs);
      q.is_ground = ground;
      q.layer = 7'(lay);
      q.last = lst;
      expected_quads.insert(expected_quads.size(), q);
    endfunction

    function void take_item(logic func, logic [14:0] id, logic [2:0] pv,
                            logic [5:0] col, logic [5:0] row);
      int unsigned ts, prio, lay, px, py, slot, pat, qsrc, xoff, base_y, t;
      logic [1:0]  kind;
      logic [7:0]  e;
      logic        ground;
      if (!func) begin
        if (id < STORE_DEPTH) prio_store[id] = pv;
        return;
      end
      if (id < AUTOTILE_FIRST) return;
      prio = 0;
      if (id < prio_count && id < STORE_DEPTH) prio = prio_store[id];
      if (prio > PRIORITY_MAX) return;
      ground = (prio == 0);
      lay = ground ? 0 : row + prio;
      ts = tile_size;
      if (ts == 0) ts = 1;
      if (ts > 64) ts = 64;
      px = 2 * ts * col;
      py = 2 * ts * row;
      if (id < TILESET_FIRST) begin
        slot = id / 48 - 1;
        pat = id % 48;
        kind = kinds[2*slot +: 2];
        base_y = 1 + 8 * ts * slot;
        if (kind == KIND_ABSENT) return;
        if (kind == KIND_SINGLE) begin
          push_quad(1, base_y, 2*ts - 2, px, py, 2*ts, ground, lay, 1'b1);
          return;
        end
        qsrc = (ts >= 2) ? ts - 2 : 0;
        xoff = (kind == KIND_STATIC) ? 6 * ts : 0;
        for (int q = 0; q < 4; q++) begin
          e = QSRC[pat*4 + q];
          push_quad(e[7:4] * ts + 1 + xoff, e[3:0] * ts + base_y, qsrc,
                    px + ((q & 1) ? ts : 0), py + ((q & 2) ? ts : 0), ts,
                    ground, lay, q == 3);
        end
        return;
      end
      t = id - TILESET_FIRST;
      push_quad(2*ts*(12 + t % 8) + 1, 2*ts*(t / 8) + 1, 2*ts - 2, px, py, 2*ts,
                ground, lay, 1'b1);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_quad(quad_t a);
      quad_t x;
      if (expected_quads.size() == 0) begin
        $error("unexpected quad transfer: tex_x %0d pos_x %0d", a.tex_x, a.pos_x);
        errors++;
        return;
      end
      x = expected_quads.pop_front();
      cmp("tex_x", x.tex_x, a.tex_x);
      cmp("tex_y", x.tex_y, a.tex_y);
      cmp("tex_size", x.tex_size, a.tex_size);
      cmp("pos_x", x.pos_x, a.pos_x);
      cmp("pos_y", x.pos_y, a.pos_y);
      cmp("quad_size", x.quad_size, a.quad_size);
      cmp("is_ground", x.is_ground, a.is_ground);
      cmp("layer", x.layer, a.layer);
      cmp("last", x.last, a.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [14:0] in_tile_id;
  logic [2:0]  in_priority_value;
  logic [5:0]  in_col;
  logic [5:0]  in_row;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] out_tex_x;
  logic [19:0] out_tex_y;
  logic [6:0]  out_tex_size;
  logic [12:0] out_pos_x;
  logic [12:0] out_pos_y;
  logic [7:0]  out_quad_size;
  logic        out_is_ground;
  logic [6:0]  out_layer;
  logic        out_last;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tile_quad_expander i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_tile_id(in_tile_id), .in_priority_value(in_priority_value),
    .in_col(in_col), .in_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tex_x(out_tex_x), .out_tex_y(out_tex_y), .out_tex_size(out_tex_size),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_quad_size(out_quad_size),
    .out_is_ground(out_is_ground), .out_layer(out_layer), .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  quad_tracker tracker = new();
  bit          written[STORE_DEPTH];
  int          burst_left = 0;
  int          stall_pct = 0;
  bit          gaps_on = 0;
  bit          hold_req = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        hold_req = 0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    quad_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.tex_x = out_tex_x;
      a.tex_y = out_tex_y;
      a.tex_size = out_tex_size;
      a.pos_x = out_pos_x;
      a.pos_y = out_pos_y;
      a.quad_size = out_quad_size;
      a.is_ground = out_is_ground;
      a.layer = out_layer;
      a.last = out_last;
      tracker.check_quad(a);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    tracker.set_reg(idx, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_item(logic func, logic [14:0] id, logic [2:0] pv,
                           logic [5:0] col, logic [5:0] row);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_tile_id <= id;
    in_priority_value <= pv;
    in_col <= col;
    in_row <= row;
    do @(posedge clk); while (in_stall);
    tracker.take_item(func, id, pv, col, row);
    if (!func && id < STORE_DEPTH) written[id] = 1;
    burst_left--;
  endtask

  task automatic send_cell(logic [14:0] id, logic [5:0] col, logic [5:0] row);
    if (id < tracker.prio_count && id < STORE_DEPTH && !written[id])
      send_item(1'b0, id, 3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom));
    send_item(1'b1, id, 3'($urandom), col, row);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tracker.expected_quads.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int          ts_tab[6] = '{1, 64, 0, 127, 17, 32};
    int          kinds_tab[6] = '{16383, 10922, 5461, 0, 14649, 16383};
    int          count_tab[6] = '{8192, 0, 500, 8192, 1000, 384};
    logic [14:0] id;
    int          r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_tile_id = '0;
    in_priority_value = '0;
    in_col = '0;
    in_row = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_AUTOTILE_KINDS, 32'd14649);
    write_reg(REG_PRIORITY_COUNT, 32'd8192);
    send_item(1'b0, 15'd100, 3'd0, 6'd0, 6'd0);
    send_item(1'b0, 15'd101, 3'd5, 6'd63, 6'd63);
    send_item(1'b0, 15'd102, 3'd6, 6'd0, 6'd0);
    send_item(1'b0, 15'd103, 3'd7, 6'd0, 6'd0);
    send_item(1'b0, 15'd8191, 3'd3, 6'd0, 6'd0);
    send_item(1'b0, 15'd8192, 3'd7, 6'd0, 6'd0);
    send_item(1'b0, 15'd32767, 3'd2, 6'd0, 6'd0);
    send_cell(15'd0, 6'd0, 6'd0);
    send_cell(15'd47, 6'd63, 6'd63);
    send_cell(15'd48, 6'd0, 6'd0);
    send_cell(15'd95, 6'd63, 6'd63);
    send_cell(15'd96, 6'd1, 6'd2);
    send_cell(15'd100, 6'd5, 6'd7);
    send_cell(15'd101, 6'd63, 6'd63);
    send_cell(15'd102, 6'd3, 6'd3);
    send_cell(15'd103, 6'd3, 6'd3);
    send_cell(15'd144, 6'd10, 6'd20);
    send_cell(15'd192, 6'd4, 6'd4);
    send_cell(15'd383, 6'd63, 6'd0);
    send_cell(15'd384, 6'd63, 6'd63);
    send_cell(15'd8191, 6'd0, 6'd63);
    send_cell(15'd8192, 6'd31, 6'd32);
    send_cell(15'd32767, 6'd62, 6'd1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_TILE_SIZE, ts_tab[p]);
      write_reg(REG_AUTOTILE_KINDS, kinds_tab[p]);
      write_reg(REG_PRIORITY_COUNT, count_tab[p]);
      gaps_on = (p != 0);
      stall_pct = (p == 0) ? 0 : $urandom_range(10, 50);
      if (p == 2) hold_req = 1;
      for (int n = 0; n < 18; n++) begin
        r = $urandom_range(0, 19);
        if (r < 3) begin
          send_item(1'b0, 15'($urandom), 3'($urandom), 6'($urandom), 6'($urandom));
        end else begin
          r = $urandom_range(0, 9);
          if (r == 0) id = 15'($urandom_range(0, 47));
          else if (r < 6) id = 15'($urandom_range(48, 383));
          else if (r < 8) id = 15'($urandom_range(384, 9000));
          else id = 15'($urandom);
          send_cell(id, 6'($urandom), 6'($urandom));
        end
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.expected_quads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
